@@ rtl/core/ccrcp_pkg.sv @@
// ----------------------------------------------------------------------------
// ccrcp_pkg : shared types and constants of the Catmull-Rom curve point block
// Field widths, fixed-point formats, request structs and the engine states.
// ----------------------------------------------------------------------------
`default_nettype none

package ccrcp_pkg;

    // Field widths
    localparam int COORD_BITS      = 16;
    localparam int STEP_BITS       = 10;
    localparam int IDX_BITS        = 3;

    // Ring size default and config reset
    localparam int RING_POINTS_DEF = 8;
    localparam int STEPS_RESET     = 200;

    // Fixed point: u, u^2, u^3 in Q1.16, quotient needs FRAC_BITS + 1 bits
    localparam int FRAC_BITS       = 16;
    localparam int U_BITS          = FRAC_BITS + 1;
    localparam int NUM_BITS        = STEP_BITS + FRAC_BITS;
    localparam int ONE_Q           = 1 << FRAC_BITS;
    localparam int HALF_Q          = 1 << (FRAC_BITS - 1);

    // Blend: doubled weights, products and accumulator
    localparam int WGT_BITS        = 20;
    localparam int PROD_BITS       = WGT_BITS + COORD_BITS;
    localparam int ACC_BITS        = PROD_BITS + 2;
    localparam int RND_SHIFT       = FRAC_BITS + 1;
    localparam int TAPS            = 4;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_EVAL  = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd                          cmd;
        logic [IDX_BITS-1:0]           point_index;
        logic signed [COORD_BITS-1:0]  coord_x;
        logic signed [COORD_BITS-1:0]  coord_y;
        logic signed [COORD_BITS-1:0]  coord_z;
        logic [IDX_BITS-1:0]           segment_index;
        logic [STEP_BITS-1:0]          step_index;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_BITS-1:0]  curve_x;
        logic signed [COORD_BITS-1:0]  curve_y;
        logic signed [COORD_BITS-1:0]  curve_z;
        logic                          segment_end;
    } t_out_item;

    // One ring entry
    typedef struct packed {
        logic signed [COORD_BITS-1:0]  x;
        logic signed [COORD_BITS-1:0]  y;
        logic signed [COORD_BITS-1:0]  z;
    } t_point;

    // Evaluate request from the front end to the engine
    typedef struct packed {
        logic                          start;
        logic [STEP_BITS-1:0]          step_index;
        logic [STEP_BITS-1:0]          steps;
        logic [IDX_BITS-1:0]           segment_index;
    } t_eval_req;

    // Engine status
    typedef struct packed {
        logic                          busy;
        logic                          res_valid;
    } t_eng_stat;

    // Divider request and response
    typedef struct packed {
        logic                          start;
        logic [NUM_BITS-1:0]           num;
        logic [STEP_BITS-1:0]          den;
    } t_div_req;

    typedef struct packed {
        logic                          done;
        logic [U_BITS-1:0]             quo;
    } t_div_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQR,
        ST_CUBE,
        ST_WGT,
        ST_MAC,
        ST_RND,
        ST_DONE
    } t_eng_state;

endpackage

`default_nettype wire

@@ rtl/core/ccrcp_ram.sv @@
// ----------------------------------------------------------------------------
// ccrcp_ram : generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ccrcp_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 8
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  wire logic [WIDTH-1:0]           i_wr_data,
    input  wire logic                       i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]   i_rd_addr,
    output logic [WIDTH-1:0]                o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;

endmodule

`default_nettype wire

@@ rtl/core/ccrcp_div.sv @@
// ----------------------------------------------------------------------------
// ccrcp_div : iterative restoring divider for u = round(k * 2^16 / N)
// One quotient bit per cycle; done is high for a single cycle, with the final quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module ccrcp_div (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire ccrcp_pkg::t_div_req   i_req,
    output ccrcp_pkg::t_div_rsp        o_rsp
);

    localparam int SB = ccrcp_pkg::STEP_BITS;
    localparam int UB = ccrcp_pkg::U_BITS;
    localparam int NB = ccrcp_pkg::NUM_BITS;
    localparam int CW = $clog2(UB);

    logic [SB-1:0] r_rem;
    logic [SB-1:0] r_den;
    logic [UB-1:0] r_sh;     // low numerator bits shift out, quotient bits shift in
    logic [CW-1:0] r_cnt;
    logic          r_run;
    logic          r_done;

    logic [SB:0]   trial;
    logic [SB:0]   diff;
    logic          ge;

    // Trial subtract of one step
    assign trial = {r_rem, r_sh[UB-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = trial >= {1'b0, r_den};

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                if (r_cnt == CW'(UB - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // Datapath; the top numerator bits are already below N since u <= 2^16
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= {1'b0, i_req.num[NB-1:UB]};
            r_den <= i_req.den;
            r_sh  <= i_req.num[UB-1:0];
        end else if (r_run) begin
            r_rem <= ge ? diff[SB-1:0] : trial[SB-1:0];
            r_sh  <= {r_sh[UB-2:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_sh;

endmodule

`default_nettype wire

@@ rtl/core/ccrcp_eval.sv @@
// ----------------------------------------------------------------------------
// ccrcp_eval : curve point engine
// Divide for u, powers on one shared multiplier, doubled weights, then a
// four-tap read of the ring with three MAC lanes, rounding and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module ccrcp_eval #(
    parameter int RING_POINTS = ccrcp_pkg::RING_POINTS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire ccrcp_pkg::t_eval_req          i_req,
    input  wire logic                          i_res_take,
    output ccrcp_pkg::t_eng_stat               o_stat,
    output ccrcp_pkg::t_out_item               o_res,
    output logic                               o_rd_en,
    output logic [$clog2(RING_POINTS)-1:0]     o_rd_addr,
    input  wire ccrcp_pkg::t_point             i_pt
);

    localparam int AW  = $clog2(RING_POINTS);
    localparam int SW  = ((AW > ccrcp_pkg::IDX_BITS) ? AW : ccrcp_pkg::IDX_BITS) + 1;
    localparam int SB  = ccrcp_pkg::STEP_BITS;
    localparam int FB  = ccrcp_pkg::FRAC_BITS;
    localparam int UB  = ccrcp_pkg::U_BITS;
    localparam int NB  = ccrcp_pkg::NUM_BITS;
    localparam int CB  = ccrcp_pkg::COORD_BITS;
    localparam int WB  = ccrcp_pkg::WGT_BITS;
    localparam int PB  = ccrcp_pkg::PROD_BITS;
    localparam int AB  = ccrcp_pkg::ACC_BITS;
    localparam int WX  = WB + 2;
    localparam int MW  = 2 * UB;
    localparam int RW  = AB + 1 - ccrcp_pkg::RND_SHIFT;
    localparam int TW  = $clog2(ccrcp_pkg::TAPS + 2);
    localparam logic [TW-1:0] MAC_LAST = TW'(ccrcp_pkg::TAPS + 1);

    // Tap positions around the segment
    localparam logic [1:0] TAP_PREV  = 2'd0;
    localparam logic [1:0] TAP_CUR   = 2'd1;
    localparam logic [1:0] TAP_NEXT  = 2'd2;
    localparam logic [1:0] TAP_NEXT2 = 2'd3;

    localparam logic signed [RW-1:0] SAT_HI = {{(RW-CB+1){1'b0}}, {(CB-1){1'b1}}};
    localparam logic signed [RW-1:0] SAT_LO = {{(RW-CB+1){1'b1}}, {(CB-1){1'b0}}};

    ccrcp_pkg::t_eng_state r_state, n_state;

    ccrcp_pkg::t_div_req   div_req;
    ccrcp_pkg::t_div_rsp   div_rsp;

    logic [SB-1:0]         n_eff;
    logic [SB-1:0]         k_eff;
    logic [SW-1:0]         seg_ext;
    logic [SW-1:0]         seg_mod;

    logic [AW-1:0]         r_seg;
    logic                  r_seg_end;
    logic [UB-1:0]         r_u;
    logic [UB-1:0]         r_u2;
    logic [UB-1:0]         r_u3;
    logic signed [WB-1:0]  r_w [ccrcp_pkg::TAPS];

    logic [TW-1:0]         r_tap;
    logic                  r_rd_vld;
    logic [1:0]            r_rd_sel;
    logic                  r_prod_vld;
    logic signed [PB-1:0]  r_prod [3];
    logic signed [AB-1:0]  r_acc [3];
    ccrcp_pkg::t_out_item  r_res;

    logic [MW-1:0]         mul_p;
    logic [MW-1:0]         mul_r;
    logic [UB-1:0]         pw;
    logic signed [WX-1:0]  su, su2, su3;
    logic signed [WX-1:0]  w0x, w1x, w2x, w3x;
    logic [AW-1:0]         a_prev, a_next, a_next2;
    logic signed [WB-1:0]  w_sel;
    logic signed [CB-1:0]  pt_c [3];

    // Round half up at 2^17 and saturate to the coordinate range
    function automatic logic signed [CB-1:0] sat_round(input logic signed [AB-1:0] acc);
        logic signed [AB:0]   t;
        logic signed [RW-1:0] sh;
        t  = {acc[AB-1], acc} + (AB+1)'(ccrcp_pkg::ONE_Q);
        sh = RW'(t >>> ccrcp_pkg::RND_SHIFT);
        priority if (sh > SAT_HI) begin
            return SAT_HI[CB-1:0];
        end else if (sh < SAT_LO) begin
            return SAT_LO[CB-1:0];
        end else begin
            return sh[CB-1:0];
        end
    endfunction

    // Request: zero count acts as one, step clamped to count, segment wrapped
    always_comb begin
        n_eff   = (i_req.steps == '0) ? SB'(1) : i_req.steps;
        k_eff   = (i_req.step_index > n_eff) ? n_eff : i_req.step_index;
        seg_ext = SW'(i_req.segment_index);
        seg_mod = (seg_ext >= SW'(RING_POINTS)) ? seg_ext - SW'(RING_POINTS) : seg_ext;
    end

    assign div_req.start = (r_state == ccrcp_pkg::ST_IDLE) && i_req.start;
    assign div_req.num   = {k_eff, FB'(0)} + NB'(n_eff >> 1);
    assign div_req.den   = n_eff;

    ccrcp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Shared multiplier: u*u then u^2*u
    assign mul_p = r_u * ((r_state == ccrcp_pkg::ST_CUBE) ? r_u2 : r_u);
    assign mul_r = mul_p + MW'(ccrcp_pkg::HALF_Q);
    assign pw    = mul_r[FB +: UB];

    // Doubled weights
    always_comb begin
        su  = WX'(r_u);
        su2 = WX'(r_u2);
        su3 = WX'(r_u3);
        w0x = -su + (su2 <<< 1) - su3;
        w1x = WX'(2 * ccrcp_pkg::ONE_Q) - ((su2 <<< 2) + su2) + ((su3 <<< 1) + su3);
        w2x = su + (su2 <<< 2) - ((su3 <<< 1) + su3);
        w3x = su3 - su2;
    end

    // Ring neighbors of the segment start
    always_comb begin
        a_prev  = (r_seg == '0) ? AW'(RING_POINTS - 1) : r_seg - AW'(1);
        a_next  = (r_seg == AW'(RING_POINTS - 1)) ? '0 : r_seg + AW'(1);
        a_next2 = (a_next == AW'(RING_POINTS - 1)) ? '0 : a_next + AW'(1);
    end

    // Next state and read port
    always_comb begin
        n_state = r_state;
        o_rd_en = 1'b0;
        unique case (r_tap[1:0])
            TAP_PREV:  o_rd_addr = a_prev;
            TAP_CUR:   o_rd_addr = r_seg;
            TAP_NEXT:  o_rd_addr = a_next;
            TAP_NEXT2: o_rd_addr = a_next2;
        endcase
        unique case (r_state)
            ccrcp_pkg::ST_IDLE: if (i_req.start) n_state = ccrcp_pkg::ST_DIV;
            ccrcp_pkg::ST_DIV:  if (div_rsp.done) n_state = ccrcp_pkg::ST_SQR;
            ccrcp_pkg::ST_SQR:  n_state = ccrcp_pkg::ST_CUBE;
            ccrcp_pkg::ST_CUBE: n_state = ccrcp_pkg::ST_WGT;
            ccrcp_pkg::ST_WGT:  n_state = ccrcp_pkg::ST_MAC;
            ccrcp_pkg::ST_MAC: begin
                o_rd_en = (r_tap < TW'(ccrcp_pkg::TAPS));
                if (r_tap == MAC_LAST) n_state = ccrcp_pkg::ST_RND;
            end
            ccrcp_pkg::ST_RND:  n_state = ccrcp_pkg::ST_DONE;
            ccrcp_pkg::ST_DONE: if (i_res_take) n_state = ccrcp_pkg::ST_IDLE;
            default:            n_state = ccrcp_pkg::ST_IDLE;
        endcase
    end

    // State and MAC sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ccrcp_pkg::ST_IDLE;
            r_tap      <= '0;
            r_rd_vld   <= 1'b0;
            r_prod_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_vld   <= o_rd_en;
            r_prod_vld <= r_rd_vld;
            if (r_state == ccrcp_pkg::ST_WGT) begin
                r_tap <= '0;
            end else if (r_state == ccrcp_pkg::ST_MAC) begin
                r_tap <= r_tap + 1'b1;
            end
        end
    end

    // Lane operands
    assign w_sel   = r_w[r_rd_sel];
    assign pt_c[0] = i_pt.x;
    assign pt_c[1] = i_pt.y;
    assign pt_c[2] = i_pt.z;

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (div_req.start) begin
            r_seg     <= seg_mod[AW-1:0];
            r_seg_end <= (k_eff == n_eff);
        end
        if ((r_state == ccrcp_pkg::ST_DIV) && div_rsp.done) begin
            r_u <= div_rsp.quo;
        end
        if (r_state == ccrcp_pkg::ST_SQR) begin
            r_u2 <= pw;
        end
        if (r_state == ccrcp_pkg::ST_CUBE) begin
            r_u3 <= pw;
        end
        if (r_state == ccrcp_pkg::ST_WGT) begin
            r_w[0] <= w0x[WB-1:0];
            r_w[1] <= w1x[WB-1:0];
            r_w[2] <= w2x[WB-1:0];
            r_w[3] <= w3x[WB-1:0];
        end
        if (o_rd_en) begin
            r_rd_sel <= r_tap[1:0];
        end
        for (int c = 0; c < 3; c++) begin
            if (r_rd_vld) begin
                r_prod[c] <= w_sel * pt_c[c];
            end
            if (r_state == ccrcp_pkg::ST_WGT) begin
                r_acc[c] <= '0;
            end else if (r_prod_vld) begin
                r_acc[c] <= r_acc[c] + {{(AB-PB){r_prod[c][PB-1]}}, r_prod[c]};
            end
        end
        if (r_state == ccrcp_pkg::ST_RND) begin
            r_res.curve_x     <= sat_round(r_acc[0]);
            r_res.curve_y     <= sat_round(r_acc[1]);
            r_res.curve_z     <= sat_round(r_acc[2]);
            r_res.segment_end <= r_seg_end;
        end
    end

    assign o_stat.busy      = (r_state != ccrcp_pkg::ST_IDLE);
    assign o_stat.res_valid = (r_state == ccrcp_pkg::ST_DONE);
    assign o_res            = r_res;

endmodule

`default_nettype wire

@@ rtl/core/catmull_rom_closed_curve_point.sv @@
// ----------------------------------------------------------------------------
// catmull_rom_closed_curve_point : closed uniform Catmull-Rom curve evaluator
// Keeps a ring of 3-D control points in a RAM and blends four of them into
// one rounded, saturated curve point per evaluate request.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+----------------------
//  input    | in        | i_in_valid / o_in_stall    | i_in_data  (t_in_item)
//  output   | out       | o_out_valid / i_out_stall  | o_out_data (t_out_item)
//  config   | in        | i_cfg_wr_en                | i_cfg_wr_data
//
//  A write request is taken whenever the engine is idle and yields no result.
//  An evaluate request holds the engine up to its hand-off into the output
//  register: the bit-serial divider (17 quotient bits, done), the shared power
//  multiplier for u^2 then u^3, the weights, the reads of the four RAM taps,
//  rounding and the hand-off, which waits while the output register is full.
//  Reset (synchronous) clears the ring valid bits to 0.
// ----------------------------------------------------------------------------
`default_nettype none

module catmull_rom_closed_curve_point #(
    parameter int RING_POINTS = ccrcp_pkg::RING_POINTS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire ccrcp_pkg::t_in_item              i_in_data,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output ccrcp_pkg::t_out_item                  o_out_data,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [ccrcp_pkg::STEP_BITS-1:0]  i_cfg_wr_data
);

    localparam int AW = $clog2(RING_POINTS);
    localparam int SW = ((AW > ccrcp_pkg::IDX_BITS) ? AW : ccrcp_pkg::IDX_BITS) + 1;
    localparam int PW = $bits(ccrcp_pkg::t_point);

    logic [ccrcp_pkg::STEP_BITS-1:0] r_steps;
    logic [RING_POINTS-1:0]          r_pt_valid;
    logic                            r_rd_ok;
    logic                            r_out_valid;
    ccrcp_pkg::t_out_item            r_out;

    logic                  in_acc;
    logic                  out_acc;
    logic                  res_take;
    logic                  wr_en;
    logic [SW-1:0]         wr_ext;
    logic [SW-1:0]         wr_mod;
    ccrcp_pkg::t_point     wr_pt;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [PW-1:0]         ram_q;
    ccrcp_pkg::t_point     rd_pt;
    ccrcp_pkg::t_eval_req  eval_req;
    ccrcp_pkg::t_eng_stat  eng_stat;
    ccrcp_pkg::t_out_item  eng_res;

    // Request acceptance
    assign o_in_stall = eng_stat.busy;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign wr_en      = in_acc && (i_in_data.cmd == ccrcp_pkg::CMD_WRITE);

    // Write slot wrapped onto the ring
    always_comb begin
        wr_ext = SW'(i_in_data.point_index);
        wr_mod = (wr_ext >= SW'(RING_POINTS)) ? wr_ext - SW'(RING_POINTS) : wr_ext;
    end

    assign wr_pt.x = i_in_data.coord_x;
    assign wr_pt.y = i_in_data.coord_y;
    assign wr_pt.z = i_in_data.coord_z;

    // Step count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= ccrcp_pkg::STEP_BITS'(ccrcp_pkg::STEPS_RESET);
        end else if (i_cfg_wr_en) begin
            r_steps <= i_cfg_wr_data;
        end
    end

    // Ring entry valid bits; read flag registered along with the RAM read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pt_valid <= '0;
            r_rd_ok    <= 1'b0;
        end else begin
            if (wr_en) begin
                r_pt_valid[wr_mod[AW-1:0]] <= 1'b1;
            end
            if (rd_en) begin
                r_rd_ok <= r_pt_valid[rd_addr];
            end
        end
    end

    ccrcp_ram #(
        .WIDTH (PW),
        .DEPTH (RING_POINTS)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_mod[AW-1:0]),
        .i_wr_data (wr_pt),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_q)
    );

    // Never-written entries read as zero
    assign rd_pt = r_rd_ok ? ccrcp_pkg::t_point'(ram_q) : '0;

    assign eval_req.start         = in_acc && (i_in_data.cmd == ccrcp_pkg::CMD_EVAL);
    assign eval_req.step_index    = i_in_data.step_index;
    assign eval_req.steps         = r_steps;
    assign eval_req.segment_index = i_in_data.segment_index;

    ccrcp_eval #(
        .RING_POINTS (RING_POINTS)
    ) u_eval (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (eval_req),
        .i_res_take (res_take),
        .o_stat     (eng_stat),
        .o_res      (eng_res),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_pt       (rd_pt)
    );

    // Output register
    assign out_acc  = r_out_valid && !i_out_stall;
    assign res_take = eng_stat.res_valid && (!r_out_valid || out_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= eng_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

@@ rtl/core/ccrcp_chk.sv @@
// ----------------------------------------------------------------------------
// ccrcp_chk : port-level checks of the curve point block
// Watches the top-level ports only; attached by a bind below.
// ----------------------------------------------------------------------------
`default_nettype none

module ccrcp_chk (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_in_valid,
    input wire logic                             o_in_stall,
    input wire ccrcp_pkg::t_in_item              i_in_data,
    input wire logic                             o_out_valid,
    input wire logic                             i_out_stall,
    input wire ccrcp_pkg::t_out_item             o_out_data,
    input wire logic                             i_cfg_wr_en,
    input wire logic [ccrcp_pkg::STEP_BITS-1:0]  i_cfg_wr_data
);

    logic in_acc;
    logic cfg_seen;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign cfg_seen = i_cfg_wr_en && (i_cfg_wr_data == i_cfg_wr_data);

    // After reset nothing is pending and requests are taken
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("result pending or input stalled after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed or dropped");

    // No request yields a result in the very next cycle
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !o_out_valid |=> !o_out_valid)
        else $error("result appeared one cycle after a request");

    // An evaluate request occupies the engine
    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n || cfg_seen)
        in_acc && (i_in_data.cmd == ccrcp_pkg::CMD_EVAL) |=> o_in_stall)
        else $error("input not stalled after evaluate request");

endmodule

bind catmull_rom_closed_curve_point ccrcp_chk u_ccrcp_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .i_in_data     (i_in_data),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_out_data    (o_out_data),
    .i_cfg_wr_en   (i_cfg_wr_en),
    .i_cfg_wr_data (i_cfg_wr_data)
);

`default_nettype wire

@@ tb/catmull_rom_closed_curve_point_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catmull_rom_closed_curve_point_test : self-checking bench for the curve block
// Loads the control ring and evaluates curve points under several step counts.
// Every accepted evaluate request runs through a local fixed-point Catmull-Rom
// predictor, writes update its ring copy, and the monitor compares each curve point field by field.
// Both channels idle at random. One long receiver hold-off backs up the block.
// ----------------------------------------------------------------------------

module catmull_rom_closed_curve_point_test;

    localparam int RING_SIZE   = ccrcp_pkg::RING_POINTS_DEF;
    localparam int CBITS       = ccrcp_pkg::COORD_BITS;
    localparam int SBITS       = ccrcp_pkg::STEP_BITS;
    localparam int IBITS       = ccrcp_pkg::IDX_BITS;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 3000;
    localparam int SETTLE      = 40;
    localparam int PHASE_ITEMS = 105;
    localparam logic signed [CBITS-1:0] COORD_MAX = {1'b0, {(CBITS-1){1'b1}}};
    localparam logic signed [CBITS-1:0] COORD_MIN = {1'b1, {(CBITS-1){1'b0}}};

    // DUT connections; the driven ones are known from time zero
    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       in_valid     = 1'b0;
    logic                       in_stall;
    ccrcp_pkg::t_in_item        in_data      = '0;
    logic                       out_valid;
    logic                       out_stall    = 1'b0;
    ccrcp_pkg::t_out_item       out_data;
    logic                       cfg_wr_en    = 1'b0;
    logic [SBITS-1:0]           cfg_wr_data  = '0;

    // Bench state
    ccrcp_pkg::t_in_item        request_queue[$];
    ccrcp_pkg::t_out_item       curve_points_due[$];
    logic signed [CBITS-1:0]    ring_copy [RING_SIZE][3];
    logic [SBITS-1:0]           steps_cur    = SBITS'(ccrcp_pkg::STEPS_RESET);
    int                         err_count    = 0;
    int                         gap_left     = 0;
    int                         stall_left   = 0;
    int                         hold_left    = 0;
    int                         idle_cycles  = 0;
    logic                       hold_kick    = 1'b0;
    logic                       calm         = 1'b0;

    always #5 clk = ~clk;

    catmull_rom_closed_curve_point i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_in_data     (in_data),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_data    (out_data),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    // ------------------------------------------------------------------------
    // Queue helpers
    // ------------------------------------------------------------------------
    task automatic add_request(input ccrcp_pkg::t_in_item rq);
        request_queue = {request_queue, rq};
    endtask

    task automatic add_curve_point(input ccrcp_pkg::t_out_item pt);
        curve_points_due = {curve_points_due, pt};
    endtask

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Blend the four ring points around a segment into one curve point
    function automatic ccrcp_pkg::t_out_item predict_curve_point(
            input ccrcp_pkg::t_in_item rq);
        longint    n, k, u, u2, u3, acc;
        longint    wgt [4];
        int        s, idx;
        logic signed [CBITS-1:0] coord [3];
        ccrcp_pkg::t_out_item res;
        n = (steps_cur == 0) ? 1 : longint'(steps_cur);
        k = longint'(rq.step_index);
        if (k > n) k = n;
        // u, u^2, u^3 in Q1.16, each rounded half up
        u  = (k * 65536 + n / 2) / n;
        u2 = (u * u + 32768) >>> 16;
        u3 = (u2 * u + 32768) >>> 16;
        // doubled weights
        wgt[0] = -u + 2 * u2 - u3;
        wgt[1] = 2 * 65536 - 5 * u2 + 3 * u3;
        wgt[2] = u + 4 * u2 - 3 * u3;
        wgt[3] = -u2 + u3;
        s = int'(rq.segment_index) % RING_SIZE;
        for (int c = 0; c < 3; c++) begin
            acc = 0;
            for (int j = 0; j < 4; j++) begin
                idx = (s + RING_SIZE - 1 + j) % RING_SIZE;
                acc += wgt[j] * longint'(ring_copy[idx][c]);
            end
            // floor(acc / 2^17 + 1/2), then clamp
            acc = (acc + 65536) >>> 17;
            if (acc > longint'(COORD_MAX)) acc = longint'(COORD_MAX);
            if (acc < longint'(COORD_MIN)) acc = longint'(COORD_MIN);
            coord[c] = acc[CBITS-1:0];
        end
        res.curve_x     = coord[0];
        res.curve_y     = coord[1];
        res.curve_z     = coord[2];
        res.segment_end = (k == n);
        return res;
    endfunction

    // Update the ring copy or queue the expected curve point
    task automatic apply_request(input ccrcp_pkg::t_in_item rq);
        int slot;
        slot = int'(rq.point_index) % RING_SIZE;
        if (rq.cmd == ccrcp_pkg::CMD_WRITE) begin
            ring_copy[slot][0] = rq.coord_x;
            ring_copy[slot][1] = rq.coord_y;
            ring_copy[slot][2] = rq.coord_z;
        end else begin
            add_curve_point(predict_curve_point(rq));
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // ------------------------------------------------------------------------
    // Request building
    // ------------------------------------------------------------------------

    // Mostly full-range, sometimes the extremes or small values
    function automatic logic [CBITS-1:0] pick_coord();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return COORD_MAX;
        if (r == 1) return COORD_MIN;
        if (r == 2) return CBITS'($urandom_range(0, 511)) - CBITS'(256);
        return CBITS'($urandom);
    endfunction

    task automatic queue_write(input int slot, input logic [CBITS-1:0] x,
                               input logic [CBITS-1:0] y,
                               input logic [CBITS-1:0] z);
        ccrcp_pkg::t_in_item rq;
        rq.cmd           = ccrcp_pkg::CMD_WRITE;
        rq.point_index   = IBITS'(slot);
        rq.coord_x       = x;
        rq.coord_y       = y;
        rq.coord_z       = z;
        rq.segment_index = IBITS'($urandom_range(0, 7));
        rq.step_index    = SBITS'($urandom_range(0, 1023));
        add_request(rq);
    endtask

    task automatic queue_eval(input int seg, input int k);
        ccrcp_pkg::t_in_item rq;
        rq.cmd           = ccrcp_pkg::CMD_EVAL;
        rq.point_index   = IBITS'($urandom_range(0, 7));
        rq.coord_x       = pick_coord();
        rq.coord_y       = pick_coord();
        rq.coord_z       = pick_coord();
        rq.segment_index = IBITS'(seg);
        rq.step_index    = SBITS'(k);
        add_request(rq);
    endtask

    // Random mix: writes refresh the ring, evaluates favor steps up to N
    task automatic queue_random(input int count);
        int n, k, r;
        n = (steps_cur == 0) ? 1 : int'(steps_cur);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 35) begin
                queue_write($urandom_range(0, 7), pick_coord(), pick_coord(), pick_coord());
            end else begin
                r = $urandom_range(0, 9);
                if (r < 6)       k = $urandom_range(0, n);
                else if (r == 6) k = n;
                else if (r == 7) k = 0;
                else             k = $urandom_range(0, 1023);
                queue_eval($urandom_range(0, 7), k);
            end
        end
    endtask

    // Config write at an edge while the block is idle
    task automatic load_steps(input logic [SBITS-1:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        steps_cur    = value;
    endtask

    // Wait for all requests and curve points, then let the engine settle
    task automatic wait_drained();
        while (request_queue.size() != 0 || in_valid || curve_points_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : drive_requests
        logic taken;
        taken = in_valid && !in_stall;
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left  = 0;
        end else begin
            if (taken)
                apply_request(in_data);
            if (!in_valid || taken) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (request_queue.size() > 0) begin
                    in_data  <= request_queue.pop_front();
                    in_valid <= 1'b1;
                    gap_left  = calm ? 0 : $urandom_range(0, 14);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor and receiver stall
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : check_results
        ccrcp_pkg::t_out_item want;
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (curve_points_due.size() == 0) begin
                    report_mismatch($sformatf("curve point with none pending: %0d %0d %0d %0d",
                                              out_data.curve_x, out_data.curve_y,
                                              out_data.curve_z, out_data.segment_end));
                end else begin
                    want = curve_points_due.pop_front();
                    check_field("curve_x", out_data.curve_x, want.curve_x);
                    check_field("curve_y", out_data.curve_y, want.curve_y);
                    check_field("curve_z", out_data.curve_z, want.curve_z);
                    check_field("segment_end", out_data.segment_end, want.segment_end);
                end
                stall_left = calm ? 0 : $urandom_range(0, 14);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            out_stall <= (stall_left > 0) || (hold_left > 0);
        end
    end

    // Long receiver hold-off, counted on its own
    always @(posedge clk) begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_kick)
            hold_left <= HOLD_CYCLES;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // Watchdog on cycles without any accepted request or curve point
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TIMEOUT after %0d idle cycles, %0d curve points pending",
                     idle_cycles, curve_points_due.size());
            $display("catmull_rom_closed_curve_point_test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [SBITS-1:0] steps_plan [7];
        for (int i = 0; i < RING_SIZE; i++)
            for (int c = 0; c < 3; c++)
                ring_copy[i][c] = '0;
        steps_plan[0] = SBITS'(1023);
        steps_plan[1] = SBITS'(1);
        steps_plan[2] = SBITS'(0);
        steps_plan[3] = SBITS'(7);
        steps_plan[4] = SBITS'($urandom_range(1, 1023));
        steps_plan[5] = SBITS'(200);
        steps_plan[6] = SBITS'($urandom_range(2, 64));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset step count of 200
        queue_eval(0, 100);                          // ring still all zero
        queue_write(0, COORD_MIN, 16'h0000, COORD_MAX);
        queue_write(1, COORD_MAX, 16'hFFFF, COORD_MIN);
        queue_write(2, COORD_MAX, 16'h0100, COORD_MIN);
        queue_write(3, COORD_MIN, 16'hFF00, COORD_MAX);
        queue_write(4, 16'd100, -16'sd200, 16'd300);
        queue_write(5, -16'sd1000, 16'd2000, -16'sd3000);
        queue_write(6, COORD_MAX, COORD_MAX, COORD_MAX);
        queue_write(7, COORD_MIN, COORD_MIN, COORD_MIN);
        queue_eval(1, 100);                          // x overshoots high, z low
        queue_eval(0, 0);                            // u = 0 gives slot 0
        queue_eval(7, 200);                          // wraps, end of segment
        queue_eval(7, 1023);                         // step clamped to N
        queue_eval(0, 1);
        queue_eval(6, 199);
        queue_eval(3, 50);
        queue_eval(5, 150);
        queue_eval(2, 512);                          // clamped as well
        wait_drained();

        // Random phases, one step count each
        for (int p = 0; p < 7; p++) begin
            load_steps(steps_plan[p]);
            @(posedge clk);
            calm <= (p == 1 || p == 5);
            queue_random(PHASE_ITEMS);
            if (p == 3) begin
                // back up the block while requests keep coming
                @(posedge clk);
                hold_kick <= 1'b1;
                @(posedge clk);
                hold_kick <= 1'b0;
            end
            wait_drained();
        end

        if (err_count == 0)
            $display("catmull_rom_closed_curve_point_test passed");
        else
            $display("catmull_rom_closed_curve_point_test failed");
        $finish;
    end

endmodule
